// ----- design/sws_pkg.sv -----
// Shared types and constants of the six-wheel skid-steer mixer.
`default_nettype none
package sws_pkg;

  localparam logic [1:0] REQ_MANUAL   = 2'd0;
  localparam logic [1:0] REQ_AUTO     = 2'd1;
  localparam logic [1:0] REQ_GAMEPAD  = 2'd2;
  localparam logic [1:0] REQ_DEADLINE = 2'd3;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_SPIN = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  localparam logic [1:0] CFG_HALF_TRACK  = 2'd0;
  localparam logic [1:0] CFG_AXLE_OFFSET = 2'd1;

  localparam logic [15:0] HALF_TRACK_RESET  = 16'd256;
  localparam logic [15:0] AXLE_OFFSET_RESET = 16'd256;

  localparam logic [31:0] RADIUS_LIMIT = 32'h7FFF_0000;

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_STOP = 3'd1,
    CMD_HOLD = 3'd2,
    CMD_SAME = 3'd3,
    CMD_MIX  = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [15:0] speed;
    logic signed [15:0] steer;
    logic [15:0]        half_track;
    logic [15:0]        axle_offset;
    logic               auto_mode;
    logic               handbrake;
  } cmd_t;

endpackage
`default_nettype wire

// ----- design/six_wheel_skid_steer_mixer.sv -----
// Top level of the six-wheel skid-steer speed mixer.
// Events enter through a queue-style port: an event transfers when push is high
// and full is low. Results leave the same way: the oldest result is on the
// result ports while empty is low and transfers when pop is high.
// Each event gives exactly one result. Stops, holds, gamepad events, mode
// mismatches and straight drive pass from the queue through the idle and load
// states straight to the result register. A turning drive command goes through
// the shared restoring divider (for the radius and for each of four distinct
// wheel speeds) and the shared square root unit (for each of four distances).
// A two-entry command queue lets two more events transfer while one is worked.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 is half_track and index 1 is axle_offset, and other
// indexes are ignored.
// Synchronous reset clears the handbrake, mode and stop flags, empties the
// queue and result register, and restores both geometry registers to 256.
// When the receiver stalls, the result holds and full rises once the queue fills.
`default_nettype none
module six_wheel_skid_steer_mixer import sws_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [15:0] speed,
  input  wire logic signed [15:0] steer,
  input  wire logic               pad_connected,
  input  wire logic               thumb_left,
  input  wire logic               thumb_right,
  input  wire logic               button_a,
  input  wire logic               button_b,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              action,
  output logic signed [15:0]      left_front_speed,
  output logic signed [15:0]      left_middle_speed,
  output logic signed [15:0]      left_rear_speed,
  output logic signed [15:0]      right_front_speed,
  output logic signed [15:0]      right_middle_speed,
  output logic signed [15:0]      right_rear_speed,
  output logic                    autonomous_mode,
  output logic                    handbrake_on
);

  cmd_t cmd;
  cmd_t q_data;
  logic accept;
  logic q_empty;
  logic q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  sws_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .req_type      (req_type),
    .speed         (speed),
    .steer         (steer),
    .pad_connected (pad_connected),
    .thumb_left    (thumb_left),
    .thumb_right   (thumb_right),
    .button_a      (button_a),
    .button_b      (button_b),
    .cmd           (cmd)
  );

  sws_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (cmd),
    .rd      (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  sws_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_data             (q_data),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .pop                (pop),
    .empty              (empty),
    .action             (action),
    .left_front_speed   (left_front_speed),
    .left_middle_speed  (left_middle_speed),
    .left_rear_speed    (left_rear_speed),
    .right_front_speed  (right_front_speed),
    .right_middle_speed (right_middle_speed),
    .right_rear_speed   (right_rear_speed),
    .autonomous_mode    (autonomous_mode),
    .handbrake_on       (handbrake_on)
  );

endmodule
`default_nettype wire

// ----- design/sws_front.sv -----
// Front end: configuration registers, mode flags and event classification.
`default_nettype none
module sws_front import sws_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               accept,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [15:0] speed,
  input  wire logic signed [15:0] steer,
  input  wire logic               pad_connected,
  input  wire logic               thumb_left,
  input  wire logic               thumb_right,
  input  wire logic               button_a,
  input  wire logic               button_b,
  output cmd_t                    cmd
);

  logic [15:0] half_track;
  logic [15:0] axle_offset;
  logic        handbrake;
  logic        auto_mode;
  logic        stop_sent;
  logic        handbrake_next;
  logic        auto_mode_next;
  logic        stop_sent_next;
  cmd_kind_t   kind;

  always_comb begin
    handbrake_next = handbrake;
    auto_mode_next = auto_mode;
    stop_sent_next = stop_sent;
    kind = CMD_NONE;
    case (req_type)
      REQ_MANUAL, REQ_AUTO: begin
        if ((req_type == REQ_AUTO) == auto_mode) begin
          if (speed != 16'sd0) begin
            stop_sent_next = 1'b0;
            kind = (steer == 16'sd0) ? CMD_SAME : CMD_MIX;
          end else if (handbrake) begin
            stop_sent_next = 1'b0;
            kind = CMD_HOLD;
          end else if (!stop_sent) begin
            stop_sent_next = 1'b1;
            kind = CMD_STOP;
          end
        end
      end
      REQ_GAMEPAD: begin
        if (pad_connected && thumb_left) begin
          handbrake_next = 1'b1;
        end else if (pad_connected && thumb_right) begin
          handbrake_next = 1'b0;
        end
        if (pad_connected && button_a) begin
          auto_mode_next = 1'b1;
        end else if (pad_connected && button_b) begin
          auto_mode_next = 1'b0;
        end
      end
      default: begin
        kind = CMD_STOP;
      end
    endcase
  end

  always_comb begin
    cmd.kind        = kind;
    cmd.speed       = speed;
    cmd.steer       = steer;
    cmd.half_track  = half_track;
    cmd.axle_offset = axle_offset;
    cmd.auto_mode   = auto_mode_next;
    cmd.handbrake   = handbrake_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_track  <= HALF_TRACK_RESET;
      axle_offset <= AXLE_OFFSET_RESET;
      handbrake   <= 1'b0;
      auto_mode   <= 1'b0;
      stop_sent   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_HALF_TRACK) begin
        half_track <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_AXLE_OFFSET) begin
        axle_offset <= cfg_data;
      end
      if (accept) begin
        handbrake <= handbrake_next;
        auto_mode <= auto_mode_next;
        stop_sent <= stop_sent_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/sws_fifo.sv -----
// Two-entry command queue between the front end and the back end.
`default_nettype none
module sws_fifo import sws_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wr_data,
  input  wire logic rd,
  output cmd_t      rd_data,
  output logic      full,
  output logic      empty
);

  cmd_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("command queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wptr == rptr)
    else $error("command queue pointers disagree with count");

endmodule
`default_nettype wire

// ----- design/sws_back.sv -----
// Back end: radius, wheel distances and scaled wheel speeds, plus the result register.
`default_nettype none
module sws_back import sws_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               q_data,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  wire logic               pop,
  output logic                    empty,
  output logic [1:0]              action,
  output logic signed [15:0]      left_front_speed,
  output logic signed [15:0]      left_middle_speed,
  output logic signed [15:0]      left_rear_speed,
  output logic signed [15:0]      right_front_speed,
  output logic signed [15:0]      right_middle_speed,
  output logic signed [15:0]      right_rear_speed,
  output logic                    autonomous_mode,
  output logic                    handbrake_on
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_LOAD = 11'b00000000010,
    S_DIVR = 11'b00000000100,
    S_RAD  = 11'b00000001000,
    S_DX   = 11'b00000010000,
    S_SQ   = 11'b00000100000,
    S_SQRT = 11'b00001000000,
    S_MAX  = 11'b00010000000,
    S_PROD = 11'b00100000000,
    S_DIVW = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  state_t             state;
  logic               out_wait;
  cmd_t               cur;
  logic [25:0]        div_rem;
  logic [47:0]        div_quo;
  logic [24:0]        div_dvs;
  logic [5:0]         div_cnt;
  logic [25:0]        div_shift;
  logic               div_ge;
  logic [25:0]        div_rem_next;
  logic [47:0]        div_quo_next;
  logic [31:0]        rmag;
  logic [31:0]        y2;
  logic [16:0]        spd_mag;
  logic [1:0]         k;
  logic [23:0]        dxm;
  logic [49:0]        sq_op;
  logic [25:0]        sq_rem;
  logic [24:0]        sq_root;
  logic [4:0]         sq_cnt;
  logic [27:0]        sq_shift;
  logic [27:0]        sq_trial;
  logic               sq_ge;
  logic [24:0]        wheel_dist [4];
  logic [24:0]        dmax;
  logic signed [16:0] w [4];
  logic [15:0]        steer_mag;
  logic [23:0]        hx;
  logic signed [33:0] r_s;
  logic signed [33:0] dx;
  logic [33:0]        dx_abs;
  logic [31:0]        q_sub;
  logic [24:0]        max_a;
  logic [24:0]        max_b;
  logic               reverse;
  logic               rev_left;
  logic               rev_right;
  logic               out_free;
  logic               out_load;

  assign steer_mag = cur.steer[15] ? 16'(-cur.steer) : 16'(cur.steer);
  assign hx = {cur.half_track, 8'd0};
  assign r_s = cur.steer[15] ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});
  assign dx = k[1] ? r_s - $signed({10'd0, hx}) : r_s + $signed({10'd0, hx});
  assign dx_abs = dx[33] ? 34'(-dx) : 34'(dx);
  assign q_sub = div_quo[31:0] - 32'h0001_0000;

  assign div_shift    = {div_rem[24:0], div_quo[47]};
  assign div_ge       = div_shift >= {1'b0, div_dvs};
  assign div_rem_next = div_ge ? div_shift - {1'b0, div_dvs} : div_shift;
  assign div_quo_next = {div_quo[46:0], div_ge};

  assign sq_shift = {sq_rem, sq_op[49:48]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = sq_shift >= sq_trial;

  assign max_a = (wheel_dist[0] > wheel_dist[1]) ? wheel_dist[0] : wheel_dist[1];
  assign max_b = (wheel_dist[2] > wheel_dist[3]) ? wheel_dist[2] : wheel_dist[3];

  assign reverse   = rmag < {8'd0, hx};
  assign rev_left  = reverse && cur.steer[15];
  assign rev_right = reverse && !cur.steer[15];

  assign out_free = !out_wait || pop;
  assign out_load = (state == S_LOAD && cur.kind != CMD_MIX || state == S_DONE) && out_free;
  assign q_pop = state == S_IDLE && !q_empty;
  assign empty = !out_wait;

  function automatic logic signed [15:0] neg_sat(input logic signed [16:0] v);
    logic signed [16:0] n;
    n = -v;
    neg_sat = (n > 17'sd32767) ? 16'sd32767 : n[15:0];
  endfunction

  function automatic logic signed [15:0] wheel(input logic signed [16:0] v, input logic rev);
    wheel = rev ? neg_sat(v) : v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_wait <= 1'b0;
    end else begin
      if (out_load) begin
        out_wait <= 1'b1;
      end else if (pop) begin
        out_wait <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (cur.kind == CMD_MIX) begin
            state <= S_DIVR;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DIVR: begin
          if (div_cnt == 6'd47) begin
            state <= S_RAD;
          end
        end
        S_RAD: begin
          state <= S_DX;
        end
        S_DX: begin
          state <= S_SQ;
        end
        S_SQ: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_cnt == 5'd24) begin
            state <= (k == 2'd3) ? S_MAX : S_DX;
          end
        end
        S_MAX: begin
          state <= S_PROD;
        end
        S_PROD: begin
          if (dmax != 25'd0) begin
            state <= S_DIVW;
          end else if (k == 2'd3) begin
            state <= S_DONE;
          end
        end
        S_DIVW: begin
          if (div_cnt == 6'd47) begin
            state <= (k != 2'd3) ? S_PROD : S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          cur <= q_data;
        end
      end
      S_LOAD: begin
        div_quo <= 48'h0000_8000_0000;
        div_rem <= 26'd0;
        div_dvs <= {9'd0, steer_mag};
        div_cnt <= 6'd0;
        y2      <= cur.axle_offset * cur.axle_offset;
        spd_mag <= cur.speed[15] ? 17'(-$signed({cur.speed[15], cur.speed}))
                                 : {1'b0, cur.speed};
      end
      S_DIVR, S_DIVW: begin
        if (div_cnt != 6'd48) begin
          div_quo <= div_quo_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 6'd1;
        end
        if (state == S_DIVW && div_cnt == 6'd47) begin
          w[k] <= cur.speed[15] ? -$signed(div_quo_next[16:0]) : $signed(div_quo_next[16:0]);
          if (k != 2'd3) begin
            k <= k + 2'd1;
          end
        end
      end
      S_RAD: begin
        rmag <= (q_sub > RADIUS_LIMIT) ? RADIUS_LIMIT : q_sub;
        k    <= 2'd0;
      end
      S_DX: begin
        dxm <= dx_abs[31:8];
      end
      S_SQ: begin
        sq_op   <= {1'b0, 49'(dxm * dxm) + (k[0] ? 49'd0 : {17'd0, y2})};
        sq_rem  <= 26'd0;
        sq_root <= 25'd0;
        sq_cnt  <= 5'd0;
      end
      S_SQRT: begin
        sq_op   <= {sq_op[47:0], 2'b00};
        sq_rem  <= sq_ge ? 26'(sq_shift - sq_trial) : sq_shift[25:0];
        sq_root <= {sq_root[23:0], sq_ge};
        sq_cnt  <= sq_cnt + 5'd1;
        if (sq_cnt == 5'd24) begin
          wheel_dist[k] <= {sq_root[23:0], sq_ge};
          if (k != 2'd3) begin
            k <= k + 2'd1;
          end
        end
      end
      S_MAX: begin
        dmax <= (max_a > max_b) ? max_a : max_b;
        k    <= 2'd0;
      end
      S_PROD: begin
        if (dmax == 25'd0) begin
          w[k] <= cur.speed[15] ? -$signed(spd_mag) : $signed(spd_mag);
          if (k != 2'd3) begin
            k <= k + 2'd1;
          end
        end else begin
          div_quo <= {6'd0, 42'(spd_mag * wheel_dist[k])};
          div_rem <= 26'd0;
          div_dvs <= dmax;
          div_cnt <= 6'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      autonomous_mode <= cur.auto_mode;
      handbrake_on    <= cur.handbrake;
      case (cur.kind)
        CMD_NONE: action <= ACT_NONE;
        CMD_STOP: action <= ACT_STOP;
        default:  action <= ACT_SPIN;
      endcase
      case (cur.kind)
        CMD_SAME: begin
          left_front_speed   <= cur.speed;
          left_middle_speed  <= cur.speed;
          left_rear_speed    <= cur.speed;
          right_front_speed  <= cur.speed;
          right_middle_speed <= cur.speed;
          right_rear_speed   <= cur.speed;
        end
        CMD_MIX: begin
          left_front_speed   <= wheel(w[0], rev_left);
          left_middle_speed  <= wheel(w[1], rev_left);
          left_rear_speed    <= wheel(w[0], rev_left);
          right_front_speed  <= wheel(w[2], rev_right);
          right_middle_speed <= wheel(w[3], rev_right);
          right_rear_speed   <= wheel(w[2], rev_right);
        end
        default: begin
          left_front_speed   <= 16'sd0;
          left_middle_speed  <= 16'sd0;
          left_rear_speed    <= 16'sd0;
          right_front_speed  <= 16'sd0;
          right_middle_speed <= 16'sd0;
          right_rear_speed   <= 16'sd0;
        end
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_LOAD) else $error("command taken outside idle");
  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (out_wait && !pop) |-> !out_load) else $error("result overwritten before transfer");
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    out_wait |-> (action == ACT_NONE || action == ACT_SPIN || action == ACT_STOP))
    else $error("invalid action code");

endmodule
`default_nettype wire
